/* rtl/psf_pkg.sv */
`default_nettype none

package psf_pkg;

    localparam int POS_W  = 31;
    localparam int CFG_W  = 31;
    localparam int CFG_AW = 3;
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;
    localparam int PROD_W = 63;
    localparam int FORCE_W = 32;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_SAME  = 2'd1,
        KIND_BOND  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_BOX     = 3'd0,
        CFG_CONTACT = 3'd1,
        CFG_ADH     = 3'd2,
        CFG_KREP    = 3'd3,
        CFG_KADH    = 3'd4,
        CFG_KBOND   = 3'd5
    } cfg_idx_t;

    // sideband carried alongside the square root
    typedef struct packed {
        kind_t            kind;
        logic [POS_W-1:0] adx;
        logic [POS_W-1:0] ady;
        logic             neg_dx;
        logic             neg_dy;
        logic             zero;
    } sqrt_side_t;

    // sideband carried alongside the divider
    typedef struct packed {
        logic [CFG_W-1:0] k;
        logic             neg_x;
        logic             neg_y;
        logic             active;
        logic             zero;
    } div_side_t;

endpackage

`default_nettype wire

/* rtl/psf_wrap_sq.sv */
`default_nettype none

module psf_wrap_sq (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire psf_pkg::kind_t           kind,
    input  wire logic [psf_pkg::POS_W-1:0] first_x,
    input  wire logic [psf_pkg::POS_W-1:0] first_y,
    input  wire logic [psf_pkg::POS_W-1:0] second_x,
    input  wire logic [psf_pkg::POS_W-1:0] second_y,
    input  wire logic [psf_pkg::CFG_W-1:0] box_length,
    output logic                          out_valid,
    output logic [psf_pkg::SQ_W-1:0]      sq,
    output psf_pkg::sqrt_side_t           side
);
    import psf_pkg::*;

    // wrap once to the minimum image; return {negative, magnitude}
    function automatic logic [POS_W:0] wrap_abs(input logic signed [31:0] d,
                                                input logic [CFG_W-1:0] len);
        logic [31:0]        mag;
        logic               over;
        logic signed [32:0] w;
        logic [32:0]        aw;
        mag  = d[31] ? 32'(-d) : 32'(d);
        over = {mag, 1'b0} > {2'b00, len};
        w    = {d[31], d};
        if (over) begin
            if (d[31]) begin
                w = w + $signed({2'b00, len});
            end else begin
                w = w - $signed({2'b00, len});
            end
        end
        aw = w[32] ? 33'(-w) : 33'(w);
        return {w[32], aw[POS_W-1:0]};
    endfunction

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    kind_t             k1_reg, k2_reg, k3_reg;
    logic signed [31:0] dx1_reg, dy1_reg;
    logic [POS_W:0]    wx2_reg, wy2_reg;
    logic [POS_W:0]    wx3_reg, wy3_reg;
    logic [2*POS_W-1:0] sqx3_reg, sqy3_reg;
    logic              z3_reg;
    logic [SQ_W-1:0]   sq4_reg;
    sqrt_side_t        side4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k1_reg   <= kind;
            dx1_reg  <= $signed({1'b0, first_x}) - $signed({1'b0, second_x});
            dy1_reg  <= $signed({1'b0, first_y}) - $signed({1'b0, second_y});
            k2_reg   <= k1_reg;
            wx2_reg  <= wrap_abs(dx1_reg, box_length);
            wy2_reg  <= wrap_abs(dy1_reg, box_length);
            k3_reg   <= k2_reg;
            wx3_reg  <= wx2_reg;
            wy3_reg  <= wy2_reg;
            sqx3_reg <= wx2_reg[POS_W-1:0] * wx2_reg[POS_W-1:0];
            sqy3_reg <= wy2_reg[POS_W-1:0] * wy2_reg[POS_W-1:0];
            z3_reg   <= (wx2_reg[POS_W-1:0] == '0) && (wy2_reg[POS_W-1:0] == '0);
            sq4_reg  <= SQ_W'(sqx3_reg) + SQ_W'(sqy3_reg);
            side4_reg.kind   <= k3_reg;
            side4_reg.adx    <= wx3_reg[POS_W-1:0];
            side4_reg.ady    <= wy3_reg[POS_W-1:0];
            side4_reg.neg_dx <= wx3_reg[POS_W];
            side4_reg.neg_dy <= wy3_reg[POS_W];
            side4_reg.zero   <= z3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign sq        = sq4_reg;
    assign side      = side4_reg;

endmodule

`default_nettype wire

/* rtl/psf_sqrt.sv */
`default_nettype none

module psf_sqrt (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [psf_pkg::SQ_W-1:0]   sq,
    input  wire psf_pkg::sqrt_side_t        side_in,
    output logic                            out_valid,
    output logic [psf_pkg::ROOT_W-1:0]      root,
    output psf_pkg::sqrt_side_t             side_out
);
    import psf_pkg::*;

    // one root bit per stage, most significant first
    logic [ROOT_W-1:0] vld_reg;
    logic [SQ_W-1:0]   rem_reg  [0:ROOT_W-2];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];
    sqrt_side_t        side_reg [0:ROOT_W-1];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - s;
        logic [SQ_W-1:0]   rem_in;
        logic [ROOT_W-1:0] root_in;
        sqrt_side_t        side_s;
        logic              vld_in;
        logic [SQ_W-1:0]   cand;
        logic              take;

        if (s == 0) begin : g_first
            assign rem_in  = sq;
            assign root_in = '0;
            assign side_s  = side_in;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign side_s  = side_reg[s-1];
            assign vld_in  = vld_reg[s-1];
        end

        assign cand = (SQ_W'(root_in) << (BIT + 1)) | (SQ_W'(1) << (2 * BIT));
        assign take = rem_in >= cand;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[s] <= take ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
                side_reg[s] <= side_s;
            end
        end

        if (s < ROOT_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s] <= take ? (rem_in - cand) : rem_in;
                end
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

`default_nettype wire

/* rtl/psf_div.sv */
`default_nettype none

module psf_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [psf_pkg::PROD_W-1:0] num_x,
    input  wire logic [psf_pkg::PROD_W-1:0] num_y,
    input  wire logic [psf_pkg::ROOT_W-1:0] divisor,
    input  wire psf_pkg::div_side_t         side_in,
    output logic                            out_valid,
    output logic [psf_pkg::ROOT_W-1:0]      quot_x,
    output logic [psf_pkg::ROOT_W-1:0]      quot_y,
    output psf_pkg::div_side_t              side_out
);
    import psf_pkg::*;

    // restoring division, one quotient bit per stage; the quotient
    // never exceeds ROOT_W bits since the numerator is below divisor * 2^ROOT_W
    localparam int RW = PROD_W + 1;

    logic [ROOT_W-1:0] vld_reg;
    logic [RW-1:0]     rx_reg  [0:ROOT_W-2];
    logic [RW-1:0]     ry_reg  [0:ROOT_W-2];
    logic [ROOT_W-1:0] d_reg   [0:ROOT_W-2];
    logic [ROOT_W-1:0] qx_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] qy_reg  [0:ROOT_W-1];
    div_side_t         side_reg [0:ROOT_W-1];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - s;
        logic [RW-1:0]     rx_in, ry_in, dsh;
        logic [ROOT_W-1:0] d_in, qx_in, qy_in;
        div_side_t         side_s;
        logic              vld_in, tx, ty;

        if (s == 0) begin : g_first
            assign rx_in  = RW'(num_x);
            assign ry_in  = RW'(num_y);
            assign d_in   = divisor;
            assign qx_in  = '0;
            assign qy_in  = '0;
            assign side_s = side_in;
            assign vld_in = in_valid;
        end else begin : g_next
            assign rx_in  = rx_reg[s-1];
            assign ry_in  = ry_reg[s-1];
            assign d_in   = d_reg[s-1];
            assign qx_in  = qx_reg[s-1];
            assign qy_in  = qy_reg[s-1];
            assign side_s = side_reg[s-1];
            assign vld_in = vld_reg[s-1];
        end

        assign dsh = RW'(d_in) << BIT;
        assign tx  = rx_in >= dsh;
        assign ty  = ry_in >= dsh;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                qx_reg[s]   <= tx ? (qx_in | (ROOT_W'(1) << BIT)) : qx_in;
                qy_reg[s]   <= ty ? (qy_in | (ROOT_W'(1) << BIT)) : qy_in;
                side_reg[s] <= side_s;
            end
        end

        if (s < ROOT_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rx_reg[s] <= tx ? (rx_in - dsh) : rx_in;
                    ry_reg[s] <= ty ? (ry_in - dsh) : ry_in;
                    d_reg[s]  <= d_in;
                end
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign quot_x    = qx_reg[ROOT_W-1];
    assign quot_y    = qy_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

`default_nettype wire

/* rtl/periodic_soft_pair_force_unit.sv */
`default_nettype none
// Throughput: one pair per cycle unless m_tready stalls the output; the 32-stage
// square root and the 32-stage divider are fully pipelined, one result bit per stage.
// Back-pressure on m_tready freezes every stage at once; nothing is dropped.
// Reset (aresetn low, synchronous) clears all valid bits and loads the
// configuration registers with their defaults.
module periodic_soft_pair_force_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic                        cfg_we,
    input  wire logic [psf_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [psf_pkg::CFG_W-1:0]   cfg_wdata,
    // input pairs
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [127:0] s_tdata,   // first_x, first_y, second_x, second_y, zero pad
    input  wire logic [1:0]  s_tuser,    // kind
    // forces on the first particle
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,    // force_x, force_y
    output logic [1:0]       m_tuser     // zero_distance, saturated
);
    import psf_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] box_reg, contact_reg, adh_reg, krep_reg, kadh_reg, kbond_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg     <= CFG_W'(655360);
            contact_reg <= CFG_W'(65536);
            adh_reg     <= CFG_W'(78643);
            krep_reg    <= CFG_W'(65536);
            kadh_reg    <= CFG_W'(65536);
            kbond_reg   <= CFG_W'(65536);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_BOX:     box_reg     <= cfg_wdata;
                CFG_CONTACT: contact_reg <= cfg_wdata;
                CFG_ADH:     adh_reg     <= cfg_wdata;
                CFG_KREP:    krep_reg    <= cfg_wdata;
                CFG_KADH:    kadh_reg    <= cfg_wdata;
                CFG_KBOND:   kbond_reg   <= cfg_wdata;
                default: ; // ignore writes to unused indexes
            endcase
        end
    end

    // One global advance: every stage moves when the output register is free or being taken.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stages 1-4: displacement, minimum-image wrap, squares, sum
    logic       wq_valid;
    logic [SQ_W-1:0] wq_sq;
    sqrt_side_t wq_side;

    psf_wrap_sq u_wrap_sq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .kind       (kind_t'(s_tuser)),
        .first_x    (s_tdata[30:0]),
        .first_y    (s_tdata[61:31]),
        .second_x   (s_tdata[92:62]),
        .second_y   (s_tdata[123:93]),
        .box_length (box_reg),
        .out_valid  (wq_valid),
        .sq         (wq_sq),
        .side       (wq_side)
    );

    // Stages 5-36: floor square root
    logic              sr_valid;
    logic [ROOT_W-1:0] sr_root;
    sqrt_side_t        sr_side;

    psf_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (wq_valid),
        .sq        (wq_sq),
        .side_in   (wq_side),
        .out_valid (sr_valid),
        .root      (sr_root),
        .side_out  (sr_side)
    );

    // Stage 37: pick the spring constant and form |r - contact|
    logic             act_c;
    logic [CFG_W-1:0] k_c;
    logic             lt_c, gt_c, in_adh_c;
    logic signed [ROOT_W:0] diff_c;
    logic [ROOT_W-1:0] adiff_c;

    always_comb begin
        lt_c     = sr_root < ROOT_W'(contact_reg);
        gt_c     = sr_root > ROOT_W'(contact_reg);
        in_adh_c = sr_root < ROOT_W'(adh_reg);
        act_c    = 1'b0;
        k_c      = '0;
        unique case (sr_side.kind)
            KIND_OTHER: begin
                if (lt_c) begin
                    act_c = 1'b1;
                    k_c   = krep_reg;
                end else if (gt_c && in_adh_c) begin
                    act_c = 1'b1;
                    k_c   = kadh_reg;
                end
            end
            KIND_SAME: begin
                if (lt_c) begin
                    act_c = 1'b1;
                    k_c   = krep_reg;
                end
            end
            KIND_BOND: begin
                act_c = 1'b1;
                k_c   = kbond_reg;
            end
            default: ; // no interaction
        endcase
        diff_c  = $signed({1'b0, sr_root}) - $signed({2'b00, contact_reg});
        adiff_c = diff_c[ROOT_W] ? ROOT_W'(-diff_c) : ROOT_W'(diff_c);
    end

    logic              dec_valid_reg;
    logic [ROOT_W-1:0] dec_adiff_reg, dec_r_reg;
    logic [POS_W-1:0]  dec_adx_reg, dec_ady_reg;
    div_side_t         dec_side_reg;

    // Stage 38: |diff| * |d| per component
    logic              mul_valid_reg;
    logic [PROD_W-1:0] mul_px_reg, mul_py_reg;
    logic [ROOT_W-1:0] mul_r_reg;
    div_side_t         mul_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
        end else if (en) begin
            dec_valid_reg <= sr_valid;
            mul_valid_reg <= dec_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dec_adiff_reg       <= adiff_c;
            dec_r_reg           <= sr_root;
            dec_adx_reg         <= sr_side.adx;
            dec_ady_reg         <= sr_side.ady;
            dec_side_reg.k      <= k_c;
            // force sign is that of -(r - contact) * d
            dec_side_reg.neg_x  <= diff_c[ROOT_W] == sr_side.neg_dx;
            dec_side_reg.neg_y  <= diff_c[ROOT_W] == sr_side.neg_dy;
            dec_side_reg.active <= act_c && !sr_side.zero;
            dec_side_reg.zero   <= sr_side.zero;
            mul_px_reg   <= dec_adiff_reg * dec_adx_reg;
            mul_py_reg   <= dec_adiff_reg * dec_ady_reg;
            mul_r_reg    <= dec_r_reg;
            mul_side_reg <= dec_side_reg;
        end
    end

    // Stages 39-70: divide both products by r
    logic              dv_valid;
    logic [ROOT_W-1:0] dv_qx, dv_qy;
    div_side_t         dv_side;

    psf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mul_valid_reg),
        .num_x     (mul_px_reg),
        .num_y     (mul_py_reg),
        .divisor   (mul_r_reg),
        .side_in   (mul_side_reg),
        .out_valid (dv_valid),
        .quot_x    (dv_qx),
        .quot_y    (dv_qy),
        .side_out  (dv_side)
    );

    // Stage 71: scale by the spring constant
    logic              km_valid_reg;
    logic [PROD_W-1:0] km_mx_reg, km_my_reg;
    div_side_t         km_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            km_valid_reg <= 1'b0;
        end else if (en) begin
            km_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            km_mx_reg   <= dv_qx * dv_side.k;
            km_my_reg   <= dv_qy * dv_side.k;
            km_side_reg <= dv_side;
        end
    end

    // Stage 72: drop the fraction bits, apply sign, clip to 32 bits
    function automatic logic [FORCE_W:0] clip(input logic [PROD_W-1:0] m,
                                              input logic neg);
        logic [FORCE_W:0] res;
        if (neg) begin
            if (m > PROD_W'(33'h0_8000_0000)) begin
                res = {1'b1, 32'h8000_0000};
            end else begin
                res = {1'b0, 32'(-m[FORCE_W-1:0])};
            end
        end else begin
            if (m > PROD_W'(32'h7FFF_FFFF)) begin
                res = {1'b1, 32'h7FFF_FFFF};
            end else begin
                res = {1'b0, m[FORCE_W-1:0]};
            end
        end
        return res;
    endfunction

    logic [FORCE_W:0] cx_c, cy_c;
    assign cx_c = clip(km_mx_reg >> FRACTION_BITS, km_side_reg.neg_x);
    assign cy_c = clip(km_my_reg >> FRACTION_BITS, km_side_reg.neg_y);

    logic              m_tvalid_reg;
    logic [63:0]       m_tdata_reg;
    logic [1:0]        m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= km_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (km_side_reg.active) begin
                m_tdata_reg    <= {cy_c[FORCE_W-1:0], cx_c[FORCE_W-1:0]};
                m_tuser_reg[1] <= cx_c[FORCE_W] || cy_c[FORCE_W];
            end else begin
                m_tdata_reg    <= '0;
                m_tuser_reg[1] <= 1'b0;
            end
            m_tuser_reg[0] <= km_side_reg.zero;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A coincident pair yields no force and no clipping.
    a_zero_no_force: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 64'd0 && !m_tuser[1])
        else $error("zero-distance result carries a force");

    // A clipped result has a component at a rail.
    a_sat_at_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |->
            m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000 ||
            m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000)
        else $error("saturated flag without a clipped component");

    // A held result stalls the input side.
    a_stall_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

endmodule

`default_nettype wire
